@@ src/i2c_master_bit_engine_macros.svh @@
// assertion macros for the i2c master bit engine
// expects aclk and aresetn in the scope of use
`ifndef I2C_MASTER_BIT_ENGINE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_MACROS_SVH

// same-cycle implication
`define I2CBE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define I2CBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/i2cbe_pkg.sv @@
// shared types and constants of the i2c master bit engine
// no dependencies
package i2cbe_pkg;

    localparam int CNT_W = 16;
    localparam int APB_AW = 4;

    typedef logic [CNT_W-1:0] cnt_t;
    localparam cnt_t CNT_MAX = '1;

    localparam cnt_t HIGH_RST = 16'd100;
    localparam cnt_t LOW_RST = 16'd50;
    localparam cnt_t HOLD_RST = 16'd250;
    localparam cnt_t ACK_TO_RST = 16'd250;

    // register index, paddr[3:2]
    localparam logic [1:0] REG_HIGH = 2'd0;
    localparam logic [1:0] REG_LOW = 2'd1;
    localparam logic [1:0] REG_HOLD = 2'd2;
    localparam logic [1:0] REG_ACK_TO = 2'd3;

    // mode field codes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_STOP = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ = 2'd3;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        cnt_t high_ticks;
        cnt_t low_ticks;
        cnt_t hold_ticks;
        cnt_t ack_timeout;
    } timing_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack;
    } result_t;

endpackage

@@ src/i2cbe_regs.sv @@
// apb timing registers of the i2c master bit engine
// depends on i2cbe_pkg
module i2cbe_regs
    import i2cbe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output timing_t           timing
);

    timing_t timing_reg;
    logic    wr_en;
    cnt_t    rd_val;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign timing = timing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.high_ticks <= HIGH_RST;
            timing_reg.low_ticks <= LOW_RST;
            timing_reg.hold_ticks <= HOLD_RST;
            timing_reg.ack_timeout <= ACK_TO_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_HIGH:   timing_reg.high_ticks <= pwdata[CNT_W-1:0];
                REG_LOW:    timing_reg.low_ticks <= pwdata[CNT_W-1:0];
                REG_HOLD:   timing_reg.hold_ticks <= pwdata[CNT_W-1:0];
                REG_ACK_TO: timing_reg.ack_timeout <= pwdata[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_HIGH:   rd_val = timing_reg.high_ticks;
            REG_LOW:    rd_val = timing_reg.low_ticks;
            REG_HOLD:   rd_val = timing_reg.hold_ticks;
            REG_ACK_TO: rd_val = timing_reg.ack_timeout;
            default:    rd_val = '0;
        endcase
    end

    assign prdata = {{(32-CNT_W){1'b0}}, rd_val};

endmodule

@@ src/i2cbe_front.sv @@
// input side: accepts ticks, decodes the command and queues them
// depends on i2cbe_pkg
module i2cbe_front
    import i2cbe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd_valid,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_tx_byte,
    input  logic       s_send_ack,
    input  logic       s_sda_in,
    input  logic       q_pop,
    output logic       q_valid,
    output item_t      q_item
);

    item_t      q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;
    item_t      in_item;
    cmd_t       in_cmd;

    always_comb begin
        in_cmd = CMD_NONE;
        if (s_cmd_valid) begin
            unique case (s_mode)
                MODE_START: in_cmd = CMD_START;
                MODE_STOP:  in_cmd = CMD_STOP;
                MODE_WRITE: in_cmd = CMD_WRITE;
                MODE_READ:  in_cmd = CMD_READ;
                default:    in_cmd = CMD_NONE;
            endcase
        end
    end

    assign in_item = '{cmd: in_cmd, tx_byte: s_tx_byte, send_ack: s_send_ack,
                       sda_in: s_sda_in};

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = q_mem_reg[rd_ptr_reg];
    assign push = s_valid && s_ready;
    assign pop = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ src/i2cbe_engine.sv @@
// line sequencer: one queued tick per cycle unless the output stalls; registers the result
// depends on i2cbe_pkg
module i2cbe_engine
    import i2cbe_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  timing_t timing,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_HI, PH_ST_SDA, PH_SP_A, PH_SP_B,
        PH_WR_LOW, PH_WR_HIGH, PH_AW_LOW, PH_AW_WAIT,
        PH_RD_LOW, PH_RD_HIGH, PH_RA_LOW, PH_RA_HIGH
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] bit_reg, bit_next;
    cnt_t       tick_reg, tick_next;
    logic [7:0] shift_reg, shift_next;
    logic       ack_reg, ack_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       en_reg, en_next;
    logic       nack_reg, nack_next;
    logic [7:0] rx_reg, rx_next;
    logic       done;
    logic       out_valid_reg;
    result_t    res_reg;
    logic       fire;
    cnt_t       tc_inc;
    cnt_t       dur;
    logic       expired;
    logic [3:0] bit_inc;
    logic [7:0] wr_shift;
    logic [7:0] rd_shift;

    assign fire = q_valid && (!out_valid_reg || m_ready);
    assign q_pop = fire;
    assign m_valid = out_valid_reg;
    assign m_res = res_reg;

    // saturating tick counter, compared after the increment
    assign tc_inc = (tick_reg == CNT_MAX) ? tick_reg : tick_reg + 1'b1;
    assign expired = (tc_inc >= dur);
    assign bit_inc = bit_reg + 4'd1;
    assign wr_shift = {shift_reg[6:0], 1'b0};
    assign rd_shift = {shift_reg[6:0], q_item.sda_in};

    always_comb begin
        unique case (phase_reg)
            PH_WR_LOW, PH_AW_LOW, PH_RD_LOW, PH_RA_LOW: dur = timing.low_ticks;
            PH_WR_HIGH, PH_RD_HIGH, PH_RA_HIGH:         dur = timing.high_ticks;
            PH_AW_WAIT:                                  dur = timing.ack_timeout;
            default:                                     dur = timing.hold_ticks;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        bit_next = bit_reg;
        tick_next = (phase_reg == PH_IDLE) ? tick_reg : tc_inc;
        shift_next = shift_reg;
        ack_next = ack_reg;
        scl_next = scl_reg;
        sda_next = sda_reg;
        en_next = en_reg;
        nack_next = nack_reg;
        rx_next = rx_reg;
        done = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (q_item.cmd != CMD_NONE) begin
                    bit_next = 4'd0;
                    tick_next = '0;
                end
                unique case (q_item.cmd)
                    CMD_START: begin
                        phase_next = PH_ST_HI;
                        scl_next = 1'b1; sda_next = 1'b1; en_next = 1'b1;
                    end
                    CMD_STOP: begin
                        phase_next = PH_SP_A;
                        scl_next = 1'b1; sda_next = 1'b0; en_next = 1'b1;
                    end
                    CMD_WRITE: begin
                        nack_next = 1'b0;
                        shift_next = q_item.tx_byte;
                        phase_next = PH_WR_LOW;
                        scl_next = 1'b0; sda_next = q_item.tx_byte[7]; en_next = 1'b1;
                    end
                    CMD_READ: begin
                        ack_next = q_item.send_ack;
                        shift_next = 8'd0;
                        phase_next = PH_RD_LOW;
                        scl_next = 1'b0; sda_next = 1'b1; en_next = 1'b0;
                    end
                    default: ;
                endcase
            end
            PH_ST_HI: begin
                if (expired) begin
                    phase_next = PH_ST_SDA; tick_next = '0;
                    scl_next = 1'b1; sda_next = 1'b0; en_next = 1'b1;
                end
            end
            PH_ST_SDA: begin
                if (expired) begin
                    phase_next = PH_IDLE; tick_next = '0; done = 1'b1;
                    scl_next = 1'b0; sda_next = 1'b0; en_next = 1'b1;
                end
            end
            PH_SP_A: begin
                if (expired) begin
                    phase_next = PH_SP_B; tick_next = '0;
                    scl_next = 1'b1; sda_next = 1'b1; en_next = 1'b1;
                end
            end
            PH_SP_B: begin
                if (expired) begin
                    phase_next = PH_IDLE; tick_next = '0; done = 1'b1;
                    scl_next = 1'b1; sda_next = 1'b1; en_next = 1'b1;
                end
            end
            PH_WR_LOW: begin
                if (expired) begin
                    phase_next = PH_WR_HIGH; tick_next = '0;
                    scl_next = 1'b1; en_next = 1'b1;
                end
            end
            PH_WR_HIGH: begin
                if (expired) begin
                    bit_next = bit_inc;
                    shift_next = wr_shift;
                    tick_next = '0;
                    if (!bit_inc[3]) begin
                        phase_next = PH_WR_LOW;
                        scl_next = 1'b0; sda_next = wr_shift[7]; en_next = 1'b1;
                    end else begin
                        phase_next = PH_AW_LOW;
                        scl_next = 1'b0; sda_next = 1'b1; en_next = 1'b0;
                    end
                end
            end
            PH_AW_LOW: begin
                if (expired) begin
                    phase_next = PH_AW_WAIT; tick_next = '0;
                    scl_next = 1'b1; sda_next = 1'b1; en_next = 1'b0;
                end
            end
            PH_AW_WAIT: begin
                // slave pulls sda low: ack, otherwise give up after the timeout
                if (!q_item.sda_in) begin
                    nack_next = 1'b0;
                    phase_next = PH_IDLE; tick_next = '0; done = 1'b1;
                    scl_next = 1'b0; sda_next = 1'b1; en_next = 1'b0;
                end else if (expired) begin
                    nack_next = 1'b1;
                    phase_next = PH_SP_A; tick_next = '0;
                    scl_next = 1'b1; sda_next = 1'b0; en_next = 1'b1;
                end
            end
            PH_RD_LOW: begin
                if (expired) begin
                    phase_next = PH_RD_HIGH; tick_next = '0;
                    scl_next = 1'b1; sda_next = 1'b1; en_next = 1'b0;
                end
            end
            PH_RD_HIGH: begin
                if (expired) begin
                    shift_next = rd_shift;
                    bit_next = bit_inc;
                    tick_next = '0;
                    if (!bit_inc[3]) begin
                        phase_next = PH_RD_LOW;
                        scl_next = 1'b0; sda_next = 1'b1; en_next = 1'b0;
                    end else begin
                        phase_next = PH_RA_LOW;
                        scl_next = 1'b0; sda_next = !ack_reg; en_next = 1'b1;
                    end
                end
            end
            PH_RA_LOW: begin
                if (expired) begin
                    phase_next = PH_RA_HIGH; tick_next = '0;
                    scl_next = 1'b1; en_next = 1'b1;
                end
            end
            PH_RA_HIGH: begin
                if (expired) begin
                    rx_next = shift_reg;
                    phase_next = PH_IDLE; tick_next = '0; done = 1'b1;
                    scl_next = 1'b0; en_next = 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                tick_next = '0;
                sda_next = en_reg ? sda_reg : 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            bit_reg <= 4'd0;
            tick_reg <= '0;
            shift_reg <= 8'd0;
            ack_reg <= 1'b0;
            scl_reg <= 1'b1;
            sda_reg <= 1'b1;
            en_reg <= 1'b1;
            nack_reg <= 1'b0;
            rx_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg <= phase_next;
                bit_reg <= bit_next;
                tick_reg <= tick_next;
                shift_reg <= shift_next;
                ack_reg <= ack_next;
                scl_reg <= scl_next;
                sda_reg <= sda_next;
                en_reg <= en_next;
                nack_reg <= nack_next;
                rx_reg <= rx_next;
                res_reg <= '{scl_out: scl_next, sda_out: sda_next, sda_drive: en_next,
                             busy_res: (phase_next != PH_IDLE), done_res: done,
                             rx_byte: rx_next, nack: nack_next};
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ src/i2c_master_bit_engine.sv @@
// i2c master bit engine: one input transfer per line tick, one result transfer per tick
// an accepted tick is queued, then stepped by the sequencer into the output register
// throughput: one tick per cycle while neither side stalls, set by the line sequencer
// the two-entry queue and the output register let either side stall independently
// reset (aresetn low, synchronous): bus idle, scl and sda high, timing registers to defaults
module i2c_master_bit_engine
    import i2cbe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd_valid,
    input  logic [1:0]        s_mode,
    input  logic [7:0]        s_tx_byte,
    input  logic              s_send_ack,
    input  logic              s_sda_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_scl_out,
    output logic              m_sda_out,
    output logic              m_sda_drive,
    output logic              m_busy_res,
    output logic              m_done_res,
    output logic [7:0]        m_rx_byte,
    output logic              m_nack
);

`include "i2c_master_bit_engine_macros.svh"

    timing_t timing;
    logic    q_valid;
    logic    q_pop;
    item_t   q_item;
    result_t res;

    i2cbe_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .timing  (timing)
    );

    i2cbe_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd_valid (s_cmd_valid),
        .s_mode      (s_mode),
        .s_tx_byte   (s_tx_byte),
        .s_send_ack  (s_send_ack),
        .s_sda_in    (s_sda_in),
        .q_pop       (q_pop),
        .q_valid     (q_valid),
        .q_item      (q_item)
    );

    i2cbe_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .timing  (timing),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res)
    );

    assign m_scl_out = res.scl_out;
    assign m_sda_out = res.sda_out;
    assign m_sda_drive = res.sda_drive;
    assign m_busy_res = res.busy_res;
    assign m_done_res = res.done_res;
    assign m_rx_byte = res.rx_byte;
    assign m_nack = res.nack;

    // a finished command leaves the engine idle
    `I2CBE_ASSERT_IMPL(a_done_not_busy, m_valid && m_done_res, !m_busy_res, "done while busy")
    // a released sda line reads high
    `I2CBE_ASSERT_IMPL(a_released_high, m_valid && !m_sda_drive, m_sda_out, "released sda low")
    // a sequence never finishes on the tick that starts it, so two dones never follow each other
    `I2CBE_ASSERT_NEXT(a_no_double_done, m_valid && m_ready && m_done_res,
        !(m_valid && m_done_res), "back to back done")

endmodule
